FILE: rtl/accumulator_cpu_core_8bit_assert.svh
// Assertion macros for the core's RTL; only acc8_exec.sv includes them.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ACCUMULATOR_CPU_CORE_8BIT_ASSERT_SVH
`define ACCUMULATOR_CPU_CORE_8BIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACC8_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACC8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/acc8_pkg.sv
package acc8_pkg;

	localparam int unsigned StackLowDefault  = 224;
	localparam int unsigned StackHighDefault = 255;
	localparam int unsigned MemDepth         = 256;
	localparam int unsigned AddrW            = $clog2(MemDepth);

	// Command codes
	localparam logic [1:0] CMD_STEP  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Step status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HALTED    = 3'd1;
	localparam logic [2:0] ST_INVALID   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;

	// Opcodes
	localparam logic [7:0] OP_NOP  = 8'd0;
	localparam logic [7:0] OP_LDA  = 8'd1;
	localparam logic [7:0] OP_LDB  = 8'd2;
	localparam logic [7:0] OP_ADD  = 8'd3;
	localparam logic [7:0] OP_SUB  = 8'd4;
	localparam logic [7:0] OP_AND  = 8'd5;
	localparam logic [7:0] OP_OR   = 8'd6;
	localparam logic [7:0] OP_XOR  = 8'd7;
	localparam logic [7:0] OP_NOT  = 8'd8;
	localparam logic [7:0] OP_SHL  = 8'd9;
	localparam logic [7:0] OP_SHR  = 8'd10;
	localparam logic [7:0] OP_CMP  = 8'd11;
	localparam logic [7:0] OP_JZ   = 8'd12;
	localparam logic [7:0] OP_JNZ  = 8'd13;
	localparam logic [7:0] OP_JC   = 8'd14;
	localparam logic [7:0] OP_JMP  = 8'd15;
	localparam logic [7:0] OP_LDM  = 8'd16;
	localparam logic [7:0] OP_STM  = 8'd17;
	localparam logic [7:0] OP_PUSH = 8'd18;
	localparam logic [7:0] OP_POP  = 8'd19;
	localparam logic [7:0] OP_CALL = 8'd20;
	localparam logic [7:0] OP_RET  = 8'd21;
	localparam logic [7:0] OP_HALT = 8'd22;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] mem_address;
		logic [7:0] mem_write_data;
	} acc8_req_t;

	typedef struct packed {
		logic [2:0]  step_status;
		logic [7:0]  instruction_address;
		logic [7:0]  fetched_opcode;
		logic [7:0]  accumulator;
		logic [7:0]  second_register;
		logic [7:0]  next_pc;
		logic        zero_out;
		logic        carry_out;
		logic [7:0]  mem_read_data;
		logic [31:0] executed_count;
	} acc8_rsp_t;

	// One access to the unified memory
	typedef struct packed {
		logic             en;
		logic             we;
		logic [AddrW-1:0] addr;
		logic [7:0]       wdata;
	} acc8_mem_t;

endpackage

FILE: rtl/acc8_mem.sv
module acc8_mem import acc8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  acc8_mem_t acc,
	output logic [7:0] rdata
);

	logic [7:0]          ram [MemDepth];
	logic [MemDepth-1:0] vld_q;
	logic [7:0]          rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (acc.en && acc.we) begin
			ram[acc.addr] <= acc.wdata;
		end
		if (acc.en && !acc.we) begin
			rd_q <= ram[acc.addr];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (acc.en && acc.we) begin
				vld_q[acc.addr] <= 1'b1;
			end
			if (acc.en && !acc.we) begin
				rd_vld_q <= vld_q[acc.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 8'd0;

endmodule

FILE: rtl/acc8_exec.sv
module acc8_exec import acc8_pkg::*; #(
	parameter int unsigned STACK_LOW_ADDR  = StackLowDefault,
	parameter int unsigned STACK_HIGH_ADDR = StackHighDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  acc8_req_t  item,
	output logic       idle,
	output logic       fin,
	output acc8_rsp_t  rsp,
	output acc8_mem_t  mem,
	input  logic [7:0] mem_rdata
);

	`include "accumulator_cpu_core_8bit_assert.svh"

	localparam logic [7:0] LowAddr  = 8'(STACK_LOW_ADDR);
	localparam logic [7:0] HighAddr = 8'(STACK_HIGH_ADDR);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDM  = 3'd1;
	localparam logic [2:0] S_OPC  = 3'd2;
	localparam logic [2:0] S_OPD  = 3'd3;
	localparam logic [2:0] S_LDA  = 3'd4;
	localparam logic [2:0] S_POP  = 3'd5;

	typedef struct packed {
		logic [7:0] res;
		logic       c;
	} acc8_alu_t;

	function automatic acc8_alu_t alu_f(input logic [7:0] op, input logic [7:0] a,
		input logic [7:0] b);
		acc8_alu_t r;
		logic [8:0] wide;
		r    = '0;
		wide = '0;
		unique case (op) inside
			OP_ADD: begin
				wide  = {1'b0, a} + {1'b0, b};
				r.res = wide[7:0];
				r.c   = wide[8];
			end
			OP_SUB: begin
				wide  = {1'b0, a} - {1'b0, b};
				r.res = wide[7:0];
				r.c   = wide[8];
			end
			OP_AND: r.res = a & b;
			OP_OR:  r.res = a | b;
			OP_XOR: r.res = a ^ b;
			OP_NOT: r.res = ~a;
			OP_SHL: begin
				r.res = {a[6:0], 1'b0};
				r.c   = a[7];
			end
			OP_SHR: begin
				r.res = {1'b0, a[7:1]};
				r.c   = a[0];
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	logic [2:0]  state_q, state_d;
	logic [7:0]  a_q, a_d, b_q, b_d, pc_q, pc_d, sp_q, sp_d;
	logic [7:0]  pc0_q, pc0_d, opc_q, opc_d;
	logic        z_q, z_d, c_q, c_d, halt_q, halt_d;
	logic [31:0] cnt_q, cnt_d;

	logic [2:0]  status;
	logic [7:0]  op_seen, rd_byte, sp_push, sp_pop;
	logic        push_ovf, pop_unf;
	acc8_alu_t   alu;

	// Stack pointer of zero means empty; the stack grows down from the high address.
	assign push_ovf = (sp_q != 8'd0) && (sp_q <= LowAddr);
	assign sp_push  = (sp_q == 8'd0) ? HighAddr : sp_q - 8'd1;
	assign pop_unf  = sp_q < LowAddr;
	assign sp_pop   = (sp_q == HighAddr) ? 8'd0 : sp_q + 8'd1;
	assign alu      = alu_f(mem_rdata, a_q, b_q);

	always_comb begin
		state_d = state_q;
		a_d     = a_q;
		b_d     = b_q;
		pc_d    = pc_q;
		sp_d    = sp_q;
		z_d     = z_q;
		c_d     = c_q;
		halt_d  = halt_q;
		cnt_d   = cnt_q;
		opc_d   = opc_q;
		pc0_d   = pc0_q;
		mem     = '0;
		fin     = 1'b0;
		status  = ST_OK;
		op_seen = 8'd0;
		rd_byte = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					pc0_d = pc_q;
					unique case (item.command)
						CMD_STEP: begin
							mem.en   = 1'b1;
							mem.addr = pc_q;
							state_d  = S_OPC;
						end
						CMD_WRITE: begin
							mem.en    = 1'b1;
							mem.we    = 1'b1;
							mem.addr  = item.mem_address;
							mem.wdata = item.mem_write_data;
							fin       = 1'b1;
						end
						CMD_READ: begin
							mem.en   = 1'b1;
							mem.addr = item.mem_address;
							state_d  = S_RDM;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_RDM: begin
				rd_byte = mem_rdata;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_OPC: begin
				op_seen = mem_rdata;
				opc_d   = mem_rdata;
				state_d = S_IDLE;
				if (halt_q) begin
					status = ST_HALTED;
					fin    = 1'b1;
				end else begin
					cnt_d = cnt_q + 32'd1;
					pc_d  = pc_q + 8'd1;
					fin   = 1'b1;
					unique case (mem_rdata) inside
						OP_NOP: ;
						OP_LDA, OP_LDB, OP_JZ, OP_JNZ, OP_JC, OP_JMP, OP_LDM, OP_STM,
						OP_CALL: begin
							mem.en   = 1'b1;
							mem.addr = pc_q + 8'd1;
							fin      = 1'b0;
							state_d  = S_OPD;
						end
						OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_SHL,
						OP_SHR: begin
							a_d = alu.res;
							z_d = (alu.res == 8'd0);
							c_d = alu.c;
						end
						OP_CMP: begin
							z_d = (a_q == b_q);
							c_d = (a_q < b_q);
						end
						OP_PUSH: begin
							if (push_ovf) begin
								halt_d = 1'b1;
								status = ST_OVERFLOW;
							end else begin
								sp_d      = sp_push;
								mem.en    = 1'b1;
								mem.we    = 1'b1;
								mem.addr  = sp_push;
								mem.wdata = a_q;
							end
						end
						OP_POP, OP_RET: begin
							if (pop_unf) begin
								halt_d = 1'b1;
								status = ST_UNDERFLOW;
							end else begin
								mem.en   = 1'b1;
								mem.addr = sp_q;
								fin      = 1'b0;
								state_d  = S_POP;
							end
						end
						OP_HALT: begin
							halt_d = 1'b1;
							status = ST_HALTED;
						end
						default: begin
							halt_d = 1'b1;
							status = ST_INVALID;
						end
					endcase
				end
			end
			S_OPD: begin
				op_seen = opc_q;
				pc_d    = pc_q + 8'd1;
				fin     = 1'b1;
				state_d = S_IDLE;
				unique case (opc_q) inside
					OP_LDA: begin
						a_d = mem_rdata;
						z_d = (mem_rdata == 8'd0);
					end
					OP_LDB: begin
						b_d = mem_rdata;
						z_d = (mem_rdata == 8'd0);
					end
					OP_JZ: begin
						if (z_q) begin
							pc_d = mem_rdata;
						end
					end
					OP_JNZ: begin
						if (!z_q) begin
							pc_d = mem_rdata;
						end
					end
					OP_JC: begin
						if (c_q) begin
							pc_d = mem_rdata;
						end
					end
					OP_JMP: pc_d = mem_rdata;
					OP_LDM: begin
						mem.en   = 1'b1;
						mem.addr = mem_rdata;
						fin      = 1'b0;
						state_d  = S_LDA;
					end
					OP_STM: begin
						mem.en    = 1'b1;
						mem.we    = 1'b1;
						mem.addr  = mem_rdata;
						mem.wdata = a_q;
					end
					OP_CALL: begin
						if (push_ovf) begin
							halt_d = 1'b1;
							status = ST_OVERFLOW;
						end else begin
							sp_d      = sp_push;
							mem.en    = 1'b1;
							mem.we    = 1'b1;
							mem.addr  = sp_push;
							mem.wdata = pc_q + 8'd1;
							pc_d      = mem_rdata;
						end
					end
					default: ;
				endcase
			end
			S_LDA: begin
				op_seen = opc_q;
				a_d     = mem_rdata;
				z_d     = (mem_rdata == 8'd0);
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				op_seen = opc_q;
				sp_d    = sp_pop;
				if (opc_q == OP_POP) begin
					a_d = mem_rdata;
					z_d = (mem_rdata == 8'd0);
				end else begin
					pc_d = mem_rdata;
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_q     <= 8'd0;
			b_q     <= 8'd0;
			pc_q    <= 8'd0;
			sp_q    <= 8'd0;
			z_q     <= 1'b0;
			c_q     <= 1'b0;
			halt_q  <= 1'b0;
			cnt_q   <= 32'd0;
		end else begin
			state_q <= state_d;
			a_q     <= a_d;
			b_q     <= b_d;
			pc_q    <= pc_d;
			sp_q    <= sp_d;
			z_q     <= z_d;
			c_q     <= c_d;
			halt_q  <= halt_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pc0_q <= pc0_d;
		opc_q <= opc_d;
	end

	assign idle = (state_q == S_IDLE);

	always_comb begin
		rsp                     = '0;
		rsp.step_status         = status;
		rsp.instruction_address = (state_q == S_IDLE) ? pc_q : pc0_q;
		rsp.fetched_opcode      = op_seen;
		rsp.accumulator         = a_d;
		rsp.second_register     = b_d;
		rsp.next_pc             = pc_d;
		rsp.zero_out            = z_d;
		rsp.carry_out           = c_d;
		rsp.mem_read_data       = rd_byte;
		rsp.executed_count      = cnt_d;
	end

	`ACC8_ASSERT_IMPLY(a_start_when_idle, start, state_q == S_IDLE, "request started while busy")
	`ACC8_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halted flag cleared without reset")
	`ACC8_ASSERT_NEXT(a_count_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 32'd1), "fetch count jumped")
	`ACC8_ASSERT_IMPLY(a_read_issued, (state_q == S_RDM) || (state_q == S_OPC) || (state_q == S_OPD) || (state_q == S_LDA) || (state_q == S_POP), $past(mem.en && !mem.we), "memory data used without a read")

endmodule

FILE: rtl/accumulator_cpu_core_8bit.sv
// 8-bit accumulator CPU with a 256-byte unified memory, driven one request at a time.
// The req channel carries a command (step, write byte, read byte) with an address and
// data byte; the rsp channel returns one response per request with the status, the
// program counter and opcode seen before a step, the registers and flags afterward,
// the byte read and the running count of opcodes fetched while not halted.
// Both channels use valid/ready. A one-entry request buffer lets the next request be
// accepted while the core works, and a response register holds a finished response
// until it is taken; the core starts a request only when that register is free, so a
// stalled receiver stops the core after one waiting response and one buffered request.
// Timing is set by the single memory port: one access per cycle, read data registered.
// A write finishes as the core starts it and a read once its byte returns. A step
// reads the opcode; an immediate load, jump, store, call or memory load then reads
// its operand, a pop or return reads the stack, and a memory load then reads the
// addressed byte. The response becomes valid in the cycle after the core finishes.
// Reset clears the registers, flags, stack pointer, halted flag and counter, and marks
// every memory byte as zero through per-byte valid bits, so no clearing pass is needed.
module accumulator_cpu_core_8bit import acc8_pkg::*; #(
	parameter int unsigned STACK_LOW_ADDR  = StackLowDefault,
	parameter int unsigned STACK_HIGH_ADDR = StackHighDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  acc8_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output acc8_rsp_t rsp
);

	// Request buffer between the input channel and the core.
	logic      buf_v_q;
	acc8_req_t buf_q;

	// Response register in front of the output channel.
	logic      rsp_valid_q;
	acc8_rsp_t rsp_q;

	logic       eng_idle, eng_fin, out_free, take;
	acc8_rsp_t  eng_rsp;
	acc8_mem_t  mem_acc;
	logic [7:0] mem_rdata;

	// The core begins a request only if its response will have somewhere to go.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign take      = buf_v_q && eng_idle && out_free;
	assign req_ready = !buf_v_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_v_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			buf_v_q <= 1'b1;
		end else if (take) begin
			buf_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			buf_q <= req;
		end
	end

	acc8_exec #(
		.STACK_LOW_ADDR (STACK_LOW_ADDR),
		.STACK_HIGH_ADDR(STACK_HIGH_ADDR)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take),
		.item     (buf_q),
		.idle     (eng_idle),
		.fin      (eng_fin),
		.rsp      (eng_rsp),
		.mem      (mem_acc),
		.mem_rdata(mem_rdata)
	);

	acc8_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.acc   (mem_acc),
		.rdata (mem_rdata)
	);

	// A finishing request always finds the response register free, since the
	// core held off its start until the previous response had left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_fin) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_fin) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import acc8_pkg::*;

	// The package has no name for the fourth command code; the core treats it as a no-op.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] STACK_LOW  = 8'(StackLowDefault);
	localparam logic [7:0] STACK_HIGH = 8'(StackHighDefault);

	localparam int unsigned RANDOM_ITEMS   = 1600;
	localparam int unsigned HOLD_AT        = 500;
	localparam int unsigned HOLD_CYCLES    = 250;
	localparam int unsigned DRAIN_AT       = 1000;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES  = 20;

	// One row of the directed table. When typed is set, want holds the response
	// written out by hand; otherwise the CPU model supplies it.
	typedef struct packed {
		logic      typed;
		acc8_req_t req;
		acc8_rsp_t want;
	} stim_row_t;

	// The halted flag only clears on reset, so each run ends with exactly one way of
	// stopping the core, picked by the seed.
	typedef enum int unsigned {
		END_HALT,
		END_INVALID,
		END_PUSH_FULL,
		END_CALL_FULL,
		END_POP_EMPTY,
		END_RET_EMPTY
	} halt_cause_e;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	acc8_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	acc8_rsp_t rsp;

	// CPU model state, kept in step with every request the core accepts.
	logic [7:0]  cpu_mem [256];
	logic [7:0]  acc;
	logic [7:0]  breg;
	logic [7:0]  pc;
	logic [7:0]  sp;
	logic        zf;
	logic        cf;
	logic        halted;
	logic [31:0] fetches;

	acc8_rsp_t   pending_responses [$];
	stim_row_t   stim_table [$];
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;

	accumulator_cpu_core_8bit dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// CPU model
	// ------------------------------------------------------------------

	// Reads the byte at the program counter and moves past it.
	function automatic logic [7:0] fetch_byte();
		logic [7:0] v;
		v = cpu_mem[pc];
		pc = pc + 8'd1;
		return v;
	endfunction

	function automatic void set_alu(logic [7:0] r, logic c);
		acc = r;
		zf = (r == 8'd0);
		cf = c;
	endfunction

	// The stack grows down from the top address; a pointer of zero means empty.
	function automatic logic [2:0] push_byte(logic [7:0] v);
		if (sp != 8'd0 && sp <= STACK_LOW) begin
			halted = 1'b1;
			return ST_OVERFLOW;
		end
		sp = (sp == 8'd0) ? STACK_HIGH : sp - 8'd1;
		cpu_mem[sp] = v;
		return ST_OK;
	endfunction

	function automatic logic [2:0] pop_byte(output logic [7:0] v);
		v = 8'd0;
		if (sp < STACK_LOW) begin
			halted = 1'b1;
			return ST_UNDERFLOW;
		end
		v = cpu_mem[sp];
		sp = (sp == STACK_HIGH) ? 8'd0 : sp + 8'd1;
		return ST_OK;
	endfunction

	function automatic logic [2:0] run_instruction();
		logic [7:0] op;
		logic [7:0] t;
		logic [7:0] v;
		logic [8:0] sum;
		logic [2:0] s;
		if (halted)
			return ST_HALTED;
		op = fetch_byte();
		fetches = fetches + 32'd1;
		case (op)
			OP_NOP: ;
			OP_LDA: begin
				acc = fetch_byte();
				zf = (acc == 8'd0);
			end
			OP_LDB: begin
				breg = fetch_byte();
				zf = (breg == 8'd0);
			end
			OP_ADD: begin
				sum = {1'b0, acc} + {1'b0, breg};
				set_alu(sum[7:0], sum[8]);
			end
			OP_SUB: set_alu(acc - breg, acc < breg);
			OP_AND: set_alu(acc & breg, 1'b0);
			OP_OR:  set_alu(acc | breg, 1'b0);
			OP_XOR: set_alu(acc ^ breg, 1'b0);
			OP_NOT: set_alu(~acc, 1'b0);
			OP_SHL: set_alu({acc[6:0], 1'b0}, acc[7]);
			OP_SHR: set_alu({1'b0, acc[7:1]}, acc[0]);
			OP_CMP: begin
				zf = (acc == breg);
				cf = (acc < breg);
			end
			// A conditional jump always consumes its target byte.
			OP_JZ: begin
				t = fetch_byte();
				if (zf)
					pc = t;
			end
			OP_JNZ: begin
				t = fetch_byte();
				if (!zf)
					pc = t;
			end
			OP_JC: begin
				t = fetch_byte();
				if (cf)
					pc = t;
			end
			OP_JMP: pc = fetch_byte();
			OP_LDM: begin
				t = fetch_byte();
				acc = cpu_mem[t];
				zf = (acc == 8'd0);
			end
			OP_STM: begin
				t = fetch_byte();
				cpu_mem[t] = acc;
			end
			OP_PUSH: return push_byte(acc);
			OP_POP: begin
				s = pop_byte(v);
				if (s != ST_OK)
					return s;
				acc = v;
				zf = (v == 8'd0);
			end
			// A call that overflows has already stepped over its target byte.
			OP_CALL: begin
				t = fetch_byte();
				s = push_byte(pc);
				if (s != ST_OK)
					return s;
				pc = t;
			end
			OP_RET: begin
				s = pop_byte(v);
				if (s != ST_OK)
					return s;
				pc = v;
			end
			OP_HALT: begin
				halted = 1'b1;
				return ST_HALTED;
			end
			default: begin
				halted = 1'b1;
				return ST_INVALID;
			end
		endcase
		return ST_OK;
	endfunction

	// Applies one request to the model and returns the response the core owes for it.
	function automatic acc8_rsp_t apply_request(acc8_req_t r);
		acc8_rsp_t p;
		p = '0;
		p.instruction_address = pc;
		case (r.command)
			CMD_STEP: begin
				// The opcode field shows the byte at the PC even when the core is halted.
				p.fetched_opcode = cpu_mem[pc];
				p.step_status = run_instruction();
			end
			CMD_WRITE: cpu_mem[r.mem_address] = r.mem_write_data;
			CMD_READ:  p.mem_read_data = cpu_mem[r.mem_address];
			default: ;
		endcase
		p.accumulator = acc;
		p.second_register = breg;
		p.next_pc = pc;
		p.zero_out = zf;
		p.carry_out = cf;
		p.executed_count = fetches;
		return p;
	endfunction

	// An opcode is safe when executing it now would not stop the core.
	function automatic bit opcode_is_safe(logic [7:0] op);
		if (op >= OP_HALT)
			return 1'b0;
		if ((op == OP_PUSH || op == OP_CALL) && sp != 8'd0 && sp <= STACK_LOW)
			return 1'b0;
		if ((op == OP_POP || op == OP_RET) && sp < STACK_LOW)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] pick_safe_opcode();
		logic [7:0] op;
		do
			op = 8'($urandom_range(0, OP_RET));
		while (!opcode_is_safe(op));
		return op;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Idle stretch for either side: mostly none or short, now and then long.
	// While calm is set neither side idles at all.
	function automatic int unsigned pick_idle();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void add_row(logic typed, logic [1:0] cmd, logic [7:0] addr,
			logic [7:0] data, acc8_rsp_t want = '0);
		stim_row_t row;
		row.typed = typed;
		row.req.command = cmd;
		row.req.mem_address = addr;
		row.req.mem_write_data = data;
		row.want = want;
		stim_table.push_back(row);
	endfunction

	// Offers one request and holds it until the core takes it. The model is advanced at
	// the accepting edge. Valid is left high when no gap follows, so a caller that lets
	// time pass without sending must lower it first.
	task automatic send(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
			bit typed = 1'b0, acc8_rsp_t want = '0);
		acc8_req_t   r;
		acc8_rsp_t   predicted;
		int unsigned gap;
		r.command = cmd;
		r.mem_address = addr;
		r.mem_write_data = data;
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
		predicted = apply_request(r);
		pending_responses.push_back(typed ? want : predicted);
		items_sent++;
		if (items_sent % 128 == 0)
			calm = ($urandom_range(0, 3) == 0);
		gap = pick_idle();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Plants an opcode at the PC, then executes it.
	task automatic step_with(logic [7:0] opcode);
		send(CMD_WRITE, pc, opcode);
		send(CMD_STEP, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int unsigned pick;
		bit          drained;
		halt_cause_e cause;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		drained = 1'b0;

		foreach (cpu_mem[i])
			cpu_mem[i] = 8'h00;
		acc = 8'h00;
		breg = 8'h00;
		pc = 8'h00;
		sp = 8'h00;
		zf = 1'b0;
		cf = 1'b0;
		halted = 1'b0;
		fetches = 32'd0;

		// Directed table. The first rows run from the reset state, where the whole
		// response can be written down; the short program after them is left to the model.
		add_row(1'b1, CMD_READ,   8'hFF, 8'h00, '0);
		add_row(1'b1, CMD_UNUSED, 8'hFF, 8'hFF, '0);
		add_row(1'b1, CMD_WRITE,  8'hFF, 8'hFF, '0);
		add_row(1'b1, CMD_READ,   8'hFF, 8'h00,
			acc8_rsp_t'{ST_OK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF, 32'd0});
		add_row(1'b1, CMD_STEP,   8'h00, 8'h00,
			acc8_rsp_t'{ST_OK, 8'h00, OP_NOP, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0, 8'h00, 32'd1});
		add_row(1'b0, CMD_WRITE,  8'h00, 8'h00);
		add_row(1'b0, CMD_WRITE,  8'h01, OP_LDA);
		add_row(1'b0, CMD_WRITE,  8'h02, 8'hFF);
		add_row(1'b0, CMD_STEP,   8'h00, 8'h00);
		add_row(1'b0, CMD_WRITE,  8'h03, OP_LDB);
		add_row(1'b0, CMD_WRITE,  8'h04, 8'h01);
		add_row(1'b0, CMD_STEP,   8'hFF, 8'hFF);
		// 0xFF + 0x01 wraps to zero with carry out.
		add_row(1'b0, CMD_WRITE,  8'h05, OP_ADD);
		add_row(1'b0, CMD_STEP,   8'h00, 8'h00);
		add_row(1'b0, CMD_WRITE,  8'h06, OP_CMP);
		add_row(1'b0, CMD_STEP,   8'h00, 8'h00);
		// Jump to the top address; the next fetch wraps the PC to zero.
		add_row(1'b0, CMD_WRITE,  8'h07, OP_JMP);
		add_row(1'b0, CMD_WRITE,  8'h08, 8'hFF);
		add_row(1'b0, CMD_STEP,   8'h00, 8'h00);
		add_row(1'b0, CMD_READ,   8'h80, 8'h00);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send(stim_table[i].req.command, stim_table[i].req.mem_address,
				stim_table[i].req.mem_write_data, stim_table[i].typed, stim_table[i].want);

		// Random part. Steps dominate; whenever the byte at the PC would stop the core,
		// a safe opcode is written there first so the program keeps running. Half the
		// other steps get a fresh opcode too, so every opcode but halt shows up often.
		while (items_sent < stim_table.size() + RANDOM_ITEMS) begin
			if (!drained && items_sent >= DRAIN_AT) begin
				// Let the core run dry before going on.
				drained = 1'b1;
				req_valid <= 1'b0;
				while (pending_responses.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (!opcode_is_safe(cpu_mem[pc]) || $urandom_range(0, 1) == 1)
					step_with(pick_safe_opcode());
				else
					send(CMD_STEP, 8'($urandom), 8'($urandom));
			end else if (pick < 85) begin
				send(CMD_WRITE, 8'($urandom), 8'($urandom));
			end else if (pick < 97) begin
				send(CMD_READ, 8'($urandom), 8'($urandom));
			end else begin
				send(CMD_UNUSED, 8'($urandom), 8'($urandom));
			end
		end

		// Stop the core one way, then show that steps do nothing while it is halted
		// and that memory requests still work.
		cause = halt_cause_e'($urandom_range(END_HALT, END_RET_EMPTY));
		case (cause)
			END_HALT:    step_with(OP_HALT);
			END_INVALID: step_with(8'($urandom_range(OP_HALT + 1, 255)));
			END_PUSH_FULL, END_CALL_FULL: begin
				while (sp == 8'd0 || sp > STACK_LOW)
					step_with(OP_PUSH);
				step_with(cause == END_PUSH_FULL ? OP_PUSH : OP_CALL);
			end
			default: begin
				while (sp != 8'd0)
					step_with(OP_POP);
				step_with(cause == END_POP_EMPTY ? OP_POP : OP_RET);
			end
		endcase
		repeat (3)
			send(CMD_STEP, 8'($urandom), 8'($urandom));
		pick = $urandom_range(0, 255);
		send(CMD_WRITE, 8'(pick), 8'($urandom));
		send(CMD_READ, 8'(pick), 8'h00);
		send(CMD_UNUSED, 8'($urandom), 8'($urandom));
		send(CMD_STEP, 8'($urandom), 8'($urandom));

		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------

	// Random back-pressure, plus one long hold once the sender is well under way, so
	// the response register and request buffer fill and req_ready drops.
	initial begin
		int unsigned idle;
		bit          held;
		rsp_ready = 1'b0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				idle = pick_idle();
				if (idle == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					repeat (idle) @(posedge clk);
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Every response taken is matched against the oldest outstanding request.
	always @(posedge clk) begin
		acc8_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: response with no request outstanding: %p", $time, rsp);
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				check_field("step_status", want.step_status, rsp.step_status);
				check_field("instruction_address", want.instruction_address,
					rsp.instruction_address);
				check_field("fetched_opcode", want.fetched_opcode, rsp.fetched_opcode);
				check_field("accumulator", want.accumulator, rsp.accumulator);
				check_field("second_register", want.second_register, rsp.second_register);
				check_field("next_pc", want.next_pc, rsp.next_pc);
				check_field("zero_out", want.zero_out, rsp.zero_out);
				check_field("carry_out", want.carry_out, rsp.carry_out);
				check_field("mem_read_data", want.mem_read_data, rsp.mem_read_data);
				check_field("executed_count", want.executed_count, rsp.executed_count);
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/acc8_pkg.sv
rtl/acc8_mem.sv
rtl/acc8_exec.sv
rtl/accumulator_cpu_core_8bit.sv
sim/tb_top.sv
